### hw/rtl/rangefinder_frame_parser_crc16_macros.svh
// Assertion helpers shared by the RTL that carries checks.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef RANGEFINDER_FRAME_PARSER_CRC16_MACROS_SVH
`define RANGEFINDER_FRAME_PARSER_CRC16_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define RFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rfp_pkg.sv
`default_nettype none

package rfp_pkg;

  // Frame framing bytes
  localparam logic [7:0] HDR0 = 8'h0A;
  localparam logic [7:0] HDR1 = 8'h0D;

  // CRC16-CCITT, no reflection, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int DIST_W  = 13;
  localparam int INDEX_W = 8;

  // Divide by ten: multiply by ceil(2^19 / 10) and keep the top bits
  localparam logic [WORD_W-1:0] DIV10_RECIP = 16'hCCCD;
  localparam int DIV10_SHIFT = 19;
  localparam int PROD_W = 2 * WORD_W;

  // Register indexes
  localparam logic [INDEX_W-1:0] CFG_PRECISION_CHECK_ENABLE = 8'd0;
  localparam logic [INDEX_W-1:0] CFG_PRECISION_LIMIT        = 8'd1;

  // Raw words of one good frame, handed from parser to output side
  typedef struct packed {
    logic [WORD_W-1:0] dist_raw;
    logic [WORD_W-1:0] prec;
  } record_t;

  // Configuration seen by the output side
  typedef struct packed {
    logic              check_enable;
    logic [WORD_W-1:0] limit;
  } cfg_regs_t;

  // Queue handshake between parser and output side
  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

  // One byte through the CRC register, a bit per step
  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[WORD_W-1]) begin
        c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[WORD_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rfp_byte_if.sv
`default_nettype none

interface rfp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [rfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/rfp_result_if.sv
`default_nettype none

interface rfp_result_if;
  logic                       valid;
  logic                       ready;
  logic [rfp_pkg::DIST_W-1:0] range_cm;
  logic [rfp_pkg::WORD_W-1:0] precision_word;
  logic                       reading_accepted;

  modport source (output valid, output range_cm, output precision_word,
                  output reading_accepted, input ready);
  modport sink   (input valid, input range_cm, input precision_word,
                  input reading_accepted, output ready);
endinterface

`default_nettype wire

### hw/rtl/rfp_cfg_if.sv
`default_nettype none

interface rfp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rfp_pkg::INDEX_W-1:0] index;
  logic [rfp_pkg::WORD_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rfp_front.sv
`default_nettype none

module rfp_front #(
  parameter int PAYLOAD_BYTES = 11
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rfp_pkg::BYTE_W-1:0]      in_byte,
  output rfp_pkg::queue_ctl_t                  qctl,
  input  wire logic                            q_full,
  output rfp_pkg::record_t                     rec
);

  localparam int CntW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(PAYLOAD_BYTES - 1);
  localparam logic [CntW-1:0] DistHiIdx = CntW'(3);
  localparam logic [CntW-1:0] DistLoIdx = CntW'(4);
  localparam logic [CntW-1:0] PrecHiIdx = CntW'(9);
  localparam logic [CntW-1:0] PrecLoIdx = CntW'(10);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_PAY  = 3'd2;
  localparam logic [2:0] ST_CRCH = 3'd3;
  localparam logic [2:0] ST_CRCL = 3'd4;

  logic [2:0]                 parse_state;
  logic [2:0]                 parse_state_next;
  logic [CntW-1:0]            byte_count;
  logic [rfp_pkg::WORD_W-1:0] running_crc;
  logic [rfp_pkg::WORD_W-1:0] crc_next;
  logic [rfp_pkg::WORD_W-1:0] crc_result;
  logic [rfp_pkg::BYTE_W-1:0] dist_hi;
  logic [rfp_pkg::BYTE_W-1:0] dist_lo;
  logic [rfp_pkg::BYTE_W-1:0] prec_hi;
  logic [rfp_pkg::BYTE_W-1:0] prec_lo;
  logic                       accept;
  logic                       good_frame;

  // Stall only while the queue cannot take a record
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign crc_next = rfp_pkg::crc16_byte(running_crc, in_byte);

  // Frame is good once the low CRC byte matches
  assign good_frame = accept && (parse_state == ST_CRCL) &&
                      (in_byte == crc_result[rfp_pkg::BYTE_W-1:0]);

  assign qctl.push = good_frame;
  assign qctl.full = q_full;
  assign rec.dist_raw = {dist_hi, dist_lo};
  assign rec.prec     = {prec_hi, prec_lo};

  // Next parse state
  always_comb begin
    parse_state_next = ST_IDLE;
    case (parse_state)
      ST_HDR:  parse_state_next = (in_byte == rfp_pkg::HDR1) ? ST_PAY : ST_IDLE;
      ST_PAY:  parse_state_next = (byte_count == LastIdx) ? ST_CRCH : ST_PAY;
      ST_CRCH: parse_state_next = (in_byte == crc_result[rfp_pkg::WORD_W-1:rfp_pkg::BYTE_W]) ?
                                  ST_CRCL : ST_IDLE;
      ST_CRCL: parse_state_next = ST_IDLE;
      default: parse_state_next = (in_byte == rfp_pkg::HDR0) ? ST_HDR : ST_IDLE;
    endcase
  end

  // Advance the parser on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_IDLE;
      byte_count  <= '0;
      running_crc <= rfp_pkg::CRC_INIT;
      crc_result  <= '0;
    end else if (accept) begin
      parse_state <= parse_state_next;
      if (parse_state == ST_HDR && in_byte == rfp_pkg::HDR1) begin
        byte_count  <= '0;
        running_crc <= rfp_pkg::CRC_INIT;
      end
      if (parse_state == ST_PAY) begin
        running_crc <= crc_next;
        if (byte_count == LastIdx) begin
          crc_result <= crc_next;
        end else begin
          byte_count <= byte_count + 1'b1;
        end
      end
    end
  end

  // Capture the payload bytes that make up the reading
  always_ff @(posedge clk) begin
    if (accept && parse_state == ST_PAY) begin
      if (byte_count == DistHiIdx) dist_hi <= in_byte;
      if (byte_count == DistLoIdx) dist_lo <= in_byte;
      if (byte_count == PrecHiIdx) prec_hi <= in_byte;
      if (byte_count == PrecLoIdx) prec_lo <= in_byte;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rfp_queue.sv
`default_nettype none

module rfp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rfp_pkg::queue_ctl_t  qctl,
  input  wire rfp_pkg::record_t     push_data,
  output logic                      full,
  output logic                      valid,
  input  wire logic                 pop,
  output rfp_pkg::record_t          head
);

  localparam int Depth = 2;

  rfp_pkg::record_t entries [Depth];
  logic [$clog2(Depth)-1:0] wr_ptr;
  logic [$clog2(Depth)-1:0] rd_ptr;
  logic [$clog2(Depth):0]   count;
  logic                     do_push;
  logic                     do_pop;

  assign full    = (count == ($clog2(Depth) + 1)'(Depth));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = qctl.push && !qctl.full;
  assign do_pop  = pop && valid;

  // Track occupancy and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming record
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

### hw/rtl/rfp_back.sv
`default_nettype none

module rfp_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire rfp_pkg::record_t             head,
  input  wire rfp_pkg::cfg_regs_t           cfg_regs,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rfp_pkg::DIST_W-1:0]        range_cm,
  output logic [rfp_pkg::WORD_W-1:0]        precision_word,
  output logic                              reading_accepted
);

  logic [rfp_pkg::PROD_W-1:0] prod;
  logic [rfp_pkg::DIST_W-1:0] range_val;
  logic                       ok;

  // Take a record whenever the output register is free or being emptied
  assign q_pop = q_valid && (!out_valid || out_ready);

  // Divide the raw word by ten through the reciprocal
  assign prod = rfp_pkg::PROD_W'(head.dist_raw) * rfp_pkg::PROD_W'(rfp_pkg::DIV10_RECIP);
  assign range_val = prod[rfp_pkg::DIV10_SHIFT +: rfp_pkg::DIST_W];
  assign ok   = !(cfg_regs.check_enable && (head.prec > cfg_regs.limit));

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      range_cm         <= range_val;
      precision_word   <= head.prec;
      reading_accepted <= ok;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rangefinder_frame_parser_crc16.sv
// Rangefinder frame parser. Received serial bytes enter on rx, one per cycle
// with no gaps needed while the queue has room, a rate set by the parser,
// which folds a whole byte into the CRC per cycle; the block hunts for header
// 0x0A 0x0D, collects the payload while running CRC16-CCITT (init 0xFFFF,
// poly 0x1021) over it, and on a frame whose two CRC bytes match emits one
// transaction on res: the distance in cm (payload bytes 3,4 divided by ten),
// the precision word (bytes 9,10) and an accept flag from the optional
// precision check. Bad headers or CRC bytes drop the frame silently. The
// result is presented on res through a two-entry record queue and a
// registered output stage, so rx keeps flowing while a result waits on res
// and stalls only while the queue holds two records behind it. The user must
// write registers on cfg (index 0: check enable, index 1: precision limit)
// only while idle; the block itself does not enforce this.
`default_nettype none

`include "rangefinder_frame_parser_crc16_macros.svh"

module rangefinder_frame_parser_crc16 #(
  parameter int PAYLOAD_BYTES = 11
) (
  input  wire logic     clk,
  input  wire logic     rst,
  rfp_byte_if.sink      rx,
  rfp_result_if.source  res,
  rfp_cfg_if.sink       cfg
);

  rfp_pkg::cfg_regs_t  cfg_regs;
  rfp_pkg::queue_ctl_t qctl;
  rfp_pkg::record_t    push_rec;
  rfp_pkg::record_t    head;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;

  // Configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.check_enable <= 1'b0;
      cfg_regs.limit        <= 16'd100;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rfp_pkg::CFG_PRECISION_CHECK_ENABLE: cfg_regs.check_enable <= cfg.data[0];
        rfp_pkg::CFG_PRECISION_LIMIT:        cfg_regs.limit        <= cfg.data;
        default: ;
      endcase
    end
  end

  rfp_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .in_byte  (rx.rx_byte),
    .qctl     (qctl),
    .q_full   (q_full),
    .rec      (push_rec)
  );

  rfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .qctl      (qctl),
    .push_data (push_rec),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .head      (head)
  );

  rfp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .head             (head),
    .cfg_regs         (cfg_regs),
    .out_valid        (res.valid),
    .out_ready        (res.ready),
    .range_cm         (res.range_cm),
    .precision_word   (res.precision_word),
    .reading_accepted (res.reading_accepted)
  );

  // A record is only pushed on an accepted byte, and never into a full queue
  `RFP_ASSERT_NOW(a_push_on_accept, qctl.push, rx.valid && rx.ready, "push without byte")
  `RFP_ASSERT_NOW(a_no_overflow, qctl.push, !q_full, "queue overflow")
  // With the check off every reading is accepted
  `RFP_ASSERT_NOW(a_accept_when_off, res.valid && !cfg_regs.check_enable,
                  res.reading_accepted, "reading rejected with check off")
  // A popped record always shows on the output next cycle
  `RFP_ASSERT_NEXT(a_pop_to_out, q_pop, res.valid, "popped record not presented")

endmodule

`default_nettype wire
